@@ rtl/rcfd_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rcfd_pkg: shared types and constants of the remote-control frame decoder
// Holds the frame type passed from the byte front end to the result back end,
// the field codes of the result stream and the stick decode helper.
// -----------------------------------------------------------------------------
package rcfd_pkg;

	localparam int FRAME_BYTES_DEF = 18;
	localparam int SPARE_BYTES_DEF = 16;

	// Only the first bytes of a frame are ever decoded.
	localparam int STORE_DEPTH = 16;
	localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

	localparam logic [10:0] STICK_MASK   = 11'h7FF;
	localparam int          STICK_CENTER = 1024;
	localparam logic [3:0]  SW_LEFT_MASK  = 4'hC;
	localparam logic [3:0]  SW_RIGHT_MASK = 4'h3;

	// Field codes of the result stream.
	localparam logic [3:0] FID_CH0      = 4'd0;
	localparam logic [3:0] FID_CH1      = 4'd1;
	localparam logic [3:0] FID_CH2      = 4'd2;
	localparam logic [3:0] FID_CH3      = 4'd3;
	localparam logic [3:0] FID_SW_LEFT  = 4'd4;
	localparam logic [3:0] FID_SW_RIGHT = 4'd5;
	localparam logic [3:0] FID_MOUSE_X  = 4'd6;
	localparam logic [3:0] FID_MOUSE_Y  = 4'd7;
	localparam logic [3:0] FID_MOUSE_Z  = 4'd8;
	localparam logic [3:0] FID_TOTAL_X  = 4'd9;
	localparam logic [3:0] FID_TOTAL_Y  = 4'd10;
	localparam logic [3:0] FID_TOTAL_Z  = 4'd11;
	localparam logic [3:0] FID_BTN_LEFT = 4'd12;
	localparam logic [3:0] FID_BTN_RIGHT= 4'd13;
	localparam logic [3:0] FID_KEYS     = 4'd14;
	localparam logic [3:0] FID_HIT      = 4'd15;

	typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

	// Write side of the frame queue.
	typedef struct packed {
		logic   push;
		frame_t frame;
	} rcfd_qwr_t;

	// Read side of the frame queue.
	typedef struct packed {
		logic   valid;
		frame_t frame;
	} rcfd_qrd_t;

	// An 11-bit stick reading minus the center value, sign extended to 32 bits.
	function automatic logic signed [31:0] stick_center(input logic [10:0] raw);
		logic signed [31:0] wide;
		wide = signed'({21'd0, raw & STICK_MASK}) - 32'(STICK_CENTER);
		return wide;
	endfunction

endpackage

@@ rtl/rcfd_in_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rcfd_in_if: input channel of the remote-control frame decoder
// Carries one received byte or one line-idle event per transaction.
// -----------------------------------------------------------------------------
interface rcfd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

@@ rtl/rcfd_out_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rcfd_out_if: result channel of the remote-control frame decoder
// Carries one tagged decoded field per transaction.
// -----------------------------------------------------------------------------
interface rcfd_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         field_id;
	logic signed [31:0] field_value;
	logic               last;

	modport source (output valid, output field_id, output field_value, output last,
		input ready);
	modport sink   (input valid, input field_id, input field_value, input last,
		output ready);
endinterface

@@ rtl/remote_control_frame_decoder.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// remote_control_frame_decoder: remote-control link frame decoder
// Collects UART bytes of a remote-control frame and emits its decoded fields.
// -----------------------------------------------------------------------------
// Usage:
// The in_ch channel carries one transaction per received byte (cmd low) or per
// line-idle event (cmd high). Bytes are taken one per cycle while in_ch is
// ready. An idle event ends a frame; if exactly FRAME_BYTES bytes came since
// the previous idle event, the frame is decoded, otherwise it is silently
// discarded. Bytes past FRAME_BYTES + SPARE_BYTES are dropped.
// A decoded frame appears on out_ch as 16 transactions, field_id 0 to 15, one
// per cycle while the receiver is ready; last marks field 15. The first field
// comes from the result register, loaded after the frame has entered the queue.
// A two-frame queue sits between collection and result generation. The back
// end emits sixteen fields per frame, the front end takes FRAME_BYTES bytes
// plus an idle event, so the result side keeps up at full byte rate. If the receiver
// stalls long enough to fill the queue, in_ch.ready drops until a frame slot frees.
// key_mask is written through key_mask_we/key_mask_wdata while idle.
// Reset clears the byte count, mouse totals, previous key code and key_mask.
// -----------------------------------------------------------------------------
module remote_control_frame_decoder
	import rcfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int SPARE_BYTES = SPARE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rcfd_in_if.sink     in_ch,
	rcfd_out_if.source  out_ch,
	input  logic        key_mask_we,
	input  logic [15:0] key_mask_wdata
);

	logic [15:0] key_mask_q;
	rcfd_qwr_t   q_wr;
	rcfd_qrd_t   q_rd;
	logic        q_full;
	logic        q_pop;

	// The user must write the key mask register only between frames; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mask_q <= '0;
		end else if (key_mask_we) begin
			key_mask_q <= key_mask_wdata;
		end
	end

	// Front end: counts bytes into the frame store and snapshots good frames.
	rcfd_front #(
		.FRAME_BYTES (FRAME_BYTES),
		.SPARE_BYTES (SPARE_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// Frame queue: lets the byte side run while results drain.
	rcfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.q_rd   (q_rd),
		.full   (q_full)
	);

	// Back end: emits the sixteen fields and keeps the running state.
	rcfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (q_pop),
		.key_mask (key_mask_q),
		.out_ch   (out_ch)
	);

endmodule

@@ rtl/rcfd_front.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rcfd_front: byte collection front end
// Counts received bytes into the frame store and, on a line-idle event with
// the right byte count, hands a snapshot of the frame to the queue.
// -----------------------------------------------------------------------------
module rcfd_front
	import rcfd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int SPARE_BYTES = SPARE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rcfd_in_if.sink    in_ch,
	input  logic       q_full,
	output rcfd_qwr_t  q_wr
);

	localparam int TOTAL_BYTES = FRAME_BYTES + SPARE_BYTES;
	localparam int CNT_W       = $clog2(TOTAL_BYTES + 1);

	logic [CNT_W-1:0] count_q;
	frame_t           store_q;
	logic             accept;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (in_ch.cmd) begin
				count_q <= '0;
			end else if (count_q < CNT_W'(TOTAL_BYTES)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Bytes past the store depth are counted only.
	always_ff @(posedge clk) begin
		if (accept && !in_ch.cmd && count_q < CNT_W'(STORE_DEPTH)) begin
			store_q[count_q[STORE_IDX_W-1:0]] <= in_ch.rx_byte;
		end
	end

	always_comb begin
		q_wr.push  = accept && in_ch.cmd && (count_q == CNT_W'(FRAME_BYTES));
		q_wr.frame = store_q;
	end

endmodule

@@ rtl/rcfd_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rcfd_queue: two-entry frame queue
// Decouples frame collection from result generation.
// -----------------------------------------------------------------------------
module rcfd_queue
	import rcfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rcfd_qwr_t q_wr,
	input  logic      pop,
	output rcfd_qrd_t q_rd,
	output logic      full
);

	frame_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (fill_q == 2'd2);
	assign do_push = q_wr.push && !full;
	assign do_pop  = pop && (fill_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop)  rptr_q <= !rptr_q;
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= q_wr.frame;
	end

	always_comb begin
		q_rd.valid = (fill_q != 2'd0);
		q_rd.frame = mem_q[rptr_q];
	end

endmodule

@@ rtl/rcfd_back.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rcfd_back: field decode and result sequencer
// Walks the sixteen fields of the frame at the queue head, one per cycle while out_ch
// is ready, keeps the mouse totals and previous key code, and drives the result register.
// -----------------------------------------------------------------------------
module rcfd_back
	import rcfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rcfd_qrd_t   q_rd,
	output logic        pop,
	input  logic [15:0] key_mask,
	rcfd_out_if.source  out_ch
);

	logic [3:0]         idx_q;
	logic signed [31:0] totals_q [3];
	logic [15:0]        prev_keys_q;
	logic               valid_q;
	logic [3:0]         id_q;
	logic signed [31:0] value_q;
	logic               last_q;

	frame_t             s;
	logic signed [31:0] delta [3];
	logic signed [31:0] sum [3];
	logic [15:0]        keys;
	logic               hit;
	logic signed [31:0] value;
	logic               load;

	assign s = q_rd.frame;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			delta[i] = signed'({{16{s[7+2*i][7]}}, s[7+2*i], s[6+2*i]});
			sum[i]   = totals_q[i] + delta[i];
		end
		keys = {s[15], s[14]};
		hit  = ((keys & key_mask) != 16'd0) || ((prev_keys_q & key_mask) != 16'd0);

		case (idx_q)
			FID_CH0:       value = stick_center({s[1][2:0], s[0]});
			FID_CH1:       value = stick_center({s[2][5:0], s[1][7:3]});
			FID_CH2:       value = stick_center({s[4][0], s[3], s[2][7:6]});
			FID_CH3:       value = stick_center({s[5][3:0], s[4][7:1]});
			FID_SW_LEFT:   value = 32'((s[5][7:4] & SW_LEFT_MASK) >> 2);
			FID_SW_RIGHT:  value = 32'(s[5][7:4] & SW_RIGHT_MASK);
			FID_MOUSE_X:   value = delta[0];
			FID_MOUSE_Y:   value = delta[1];
			FID_MOUSE_Z:   value = delta[2];
			FID_TOTAL_X:   value = sum[0];
			FID_TOTAL_Y:   value = sum[1];
			FID_TOTAL_Z:   value = sum[2];
			FID_BTN_LEFT:  value = 32'(s[12]);
			FID_BTN_RIGHT: value = 32'(s[13]);
			FID_KEYS:      value = 32'(keys);
			FID_HIT:       value = 32'(hit);
			default:       value = '0;
		endcase
	end

	// The result register takes a new field whenever it is empty or drained.
	assign load = q_rd.valid && (!valid_q || out_ch.ready);
	assign pop  = load && (idx_q == FID_HIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= FID_CH0;
			valid_q     <= 1'b0;
			prev_keys_q <= '0;
			for (int i = 0; i < 3; i++) totals_q[i] <= '0;
		end else begin
			if (!valid_q || out_ch.ready) valid_q <= q_rd.valid;
			if (load) begin
				idx_q <= idx_q + 4'd1;
				case (idx_q)
					FID_TOTAL_X: totals_q[0] <= sum[0];
					FID_TOTAL_Y: totals_q[1] <= sum[1];
					FID_TOTAL_Z: totals_q[2] <= sum[2];
					FID_HIT:     prev_keys_q <= keys;
					default:     ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			id_q    <= idx_q;
			value_q <= value;
			last_q  <= (idx_q == FID_HIT);
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.field_id    = id_q;
	assign out_ch.field_value = value_q;
	assign out_ch.last        = last_q;

endmodule

@@ sim/remote_control_frame_decoder_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// remote_control_frame_decoder_tb: self-checking bench of the frame decoder
// Feeds byte and line-idle transactions to the decoder, predicts every decoded
// field with an in-bench model of the frame layout and compares the results in
// order. Covers extreme field values, discarded frames, buffer overflow,
// key_mask settings from zero to all ones, and a long receiver hold-off.
// -----------------------------------------------------------------------------
module remote_control_frame_decoder_tb;
	import rcfd_pkg::*;

	// The decoder runs with its default frame geometry.
	localparam int FRAME_LEN = FRAME_BYTES_DEF;
	localparam int BUF_LEN   = FRAME_BYTES_DEF + SPARE_BYTES_DEF;

	// Input command codes.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_IDLE = 1'b1;

	// Positions of the key code within a frame.
	localparam int KEY_LO_POS = 14;
	localparam int KEY_HI_POS = 15;

	// Cycles allowed for the decoder to settle after the last expected field.
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [3:0]  id;
		logic [31:0] value;
		logic        last;
	} field_result_t;

	logic        clk;
	logic        arst_n;
	logic        key_mask_we;
	logic [15:0] key_mask_wdata;

	rcfd_in_if  in_ch ();
	rcfd_out_if out_ch ();

	remote_control_frame_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.key_mask_we    (key_mask_we),
		.key_mask_wdata (key_mask_wdata)
	);

	// Mirror of the decoder state, kept by the frame predictor and write_key_mask.
	logic [7:0]  rx_store [STORE_DEPTH];
	int unsigned rx_count;
	logic [15:0] prev_keys;
	logic [31:0] mouse_sum [3];
	logic [15:0] mask_model;

	// Decoded fields still waiting to appear on the result channel.
	field_result_t expected_fields [$];

	// Frame under construction by the stimulus tasks.
	logic [7:0] frame_buf [FRAME_LEN];

	// Idling controls and the receiver hold-off request, written by the test
	// sequence only.
	bit tx_idling;
	bit rx_idling;
	int hold_len;
	int hold_req;

	// Run statistics.
	int items_sent;
	int frames_decoded;
	int idles_discarded;
	int results_checked;
	int mismatch_count;
	int cycle_count;

	// 4 ns clock period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// -------------------------------------------------------------------------
	// Frame predictor
	// -------------------------------------------------------------------------

	// An 11-bit stick reading centered around zero.
	function automatic logic [31:0] centered_stick(input logic [10:0] raw);
		return {21'd0, raw} - 32'(STICK_CENTER);
	endfunction

	// Updates the mirrored state for one accepted input transaction and queues
	// the decoded fields when an idle event closes a frame of the right length.
	function automatic void predict_frame_fields(input logic cmd, input logic [7:0] rx_byte);
		logic [31:0]   vals [16];
		logic [15:0]   keys;
		logic [31:0]   delta;
		logic          ok;
		field_result_t res;
		if (cmd == CMD_BYTE) begin
			// Bytes past the buffer end are dropped and not counted; bytes past
			// the store are counted but never decoded.
			if (rx_count < BUF_LEN) begin
				if (rx_count < STORE_DEPTH) begin
					rx_store[rx_count] = rx_byte;
				end
				rx_count++;
			end
			return;
		end
		ok = (rx_count == FRAME_LEN);
		rx_count = 0;
		if (!ok) begin
			idles_discarded++;
			return;
		end
		vals[FID_CH0] = centered_stick({rx_store[1][2:0], rx_store[0]});
		vals[FID_CH1] = centered_stick({rx_store[2][5:0], rx_store[1][7:3]});
		vals[FID_CH2] = centered_stick({rx_store[4][0], rx_store[3], rx_store[2][7:6]});
		vals[FID_CH3] = centered_stick({rx_store[5][3:0], rx_store[4][7:1]});
		vals[FID_SW_LEFT]  = {30'd0, rx_store[5][7:6]};
		vals[FID_SW_RIGHT] = {30'd0, rx_store[5][5:4]};
		for (int i = 0; i < 3; i++) begin
			delta = {{16{rx_store[7 + 2 * i][7]}}, rx_store[7 + 2 * i], rx_store[6 + 2 * i]};
			vals[FID_MOUSE_X + i] = delta;
			mouse_sum[i] = mouse_sum[i] + delta;
			vals[FID_TOTAL_X + i] = mouse_sum[i];
		end
		vals[FID_BTN_LEFT]  = {24'd0, rx_store[12]};
		vals[FID_BTN_RIGHT] = {24'd0, rx_store[13]};
		keys = {rx_store[KEY_HI_POS], rx_store[KEY_LO_POS]};
		vals[FID_KEYS] = {16'd0, keys};
		vals[FID_HIT]  = {31'd0, ((keys & mask_model) != 0) || ((prev_keys & mask_model) != 0)};
		prev_keys = keys;
		for (int i = 0; i < 16; i++) begin
			res.id    = 4'(i);
			res.value = vals[i];
			res.last  = (res.id == FID_HIT);
			expected_fields.push_back(res);
		end
		frames_decoded++;
	endfunction

	// -------------------------------------------------------------------------
	// Result checker: every accepted result transaction is matched against the
	// oldest queued field.
	// -------------------------------------------------------------------------
	always @(posedge clk) begin : result_checker
		field_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_checked++;
			if (expected_fields.size() == 0) begin
				$error("unexpected result: field_id %0d value %0d", out_ch.field_id,
					out_ch.field_value);
				mismatch_count++;
			end else begin
				want = expected_fields.pop_front();
				if (out_ch.field_id !== want.id) begin
					$error("field_id mismatch: expected %0d, got %0d", want.id,
						out_ch.field_id);
					mismatch_count++;
				end
				if (out_ch.field_value !== want.value) begin
					$error("field_value mismatch (field %0d): expected %0d, got %0d", want.id,
						$signed(want.value), out_ch.field_value);
					mismatch_count++;
				end
				if (out_ch.last !== want.last) begin
					$error("last mismatch (field %0d): expected %0b, got %0b", want.id,
						want.last, out_ch.last);
					mismatch_count++;
				end
			end
		end
	end

	// -------------------------------------------------------------------------
	// Result receiver: ready drops at random when idling is enabled. A hold-off
	// request keeps ready low until its hold countdown runs out, so that the frame
	// queue inside the decoder fills up and its input stalls.
	// -------------------------------------------------------------------------
	initial begin : result_receiver
		int seen_req;
		int hold_left;
		seen_req = 0;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != seen_req) begin
				seen_req = hold_req;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(rx_idling && $urandom_range(0, 99) < 15);
			end
		end
	end

	// Watchdog: ends a hung run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// -------------------------------------------------------------------------
	// Stimulus helpers
	// -------------------------------------------------------------------------

	// Offers one transaction and returns at the edge where it is accepted, with
	// valid still high so that back-to-back transactions follow without a gap.
	// A short idle gap comes before roughly twelve transactions in a hundred.
	task automatic send_item(input logic cmd, input logic [7:0] rx_byte);
		int gap;
		if (tx_idling && $urandom_range(0, 99) < 12) begin
			in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 2);
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.cmd     <= cmd;
		in_ch.rx_byte <= rx_byte;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
		predict_frame_fields(cmd, rx_byte);
	endtask

	// Sends the frame held in frame_buf followed by the closing idle event. The
	// byte carried with the idle event is random, since the decoder ignores it.
	task automatic send_frame();
		for (int k = 0; k < FRAME_LEN; k++) begin
			send_item(CMD_BYTE, frame_buf[k]);
		end
		send_item(CMD_IDLE, 8'($urandom_range(0, 255)));
	endtask

	// Sends a burst of random bytes of the given length and closes it.
	task automatic send_burst(input int len);
		for (int k = 0; k < len; k++) begin
			send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
		end
		send_item(CMD_IDLE, 8'($urandom_range(0, 255)));
	endtask

	// Random frame content. The key code is often zero or a single bit so that
	// the key-hit flag takes both values under every nonzero mask.
	task automatic fill_random_frame();
		logic [15:0] keys;
		for (int k = 0; k < FRAME_LEN; k++) begin
			frame_buf[k] = 8'($urandom_range(0, 255));
		end
		case ($urandom_range(0, 3))
			0: begin
				keys = '0;
			end
			1: begin
				keys = 16'd1 << $urandom_range(0, 15);
			end
			default: begin
				keys = 16'($urandom);
			end
		endcase
		frame_buf[KEY_LO_POS] = keys[7:0];
		frame_buf[KEY_HI_POS] = keys[15:8];
	endtask

	// Stops offering input and waits until every predicted field has arrived,
	// then gives the decoder time to finish any frame that produced nothing.
	task automatic wait_for_results();
		in_ch.valid <= 1'b0;
		while (expected_fields.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes key_mask; only called while the decoder is idle.
	task automatic write_key_mask(input logic [15:0] mask);
		key_mask_we    <= 1'b1;
		key_mask_wdata <= mask;
		@(posedge clk);
		key_mask_we <= 1'b0;
		mask_model = mask;
	endtask

	// -------------------------------------------------------------------------
	// Tests
	// -------------------------------------------------------------------------

	// One frame with every decoded field at an extreme: sticks at both ends of
	// their range, both switch extremes, the smallest, largest and minus-one
	// mouse deltas, both button extremes and the top and bottom key bits. It
	// runs under the reset mask, so the key-hit flag must stay low. An idle
	// event with no bytes before it follows and must produce nothing.
	task automatic test_directed_frame();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		frame_buf[0]  = 8'h00;
		frame_buf[1]  = 8'hF8;
		frame_buf[2]  = 8'h3F;
		frame_buf[3]  = 8'h00;
		frame_buf[4]  = 8'hFE;
		frame_buf[5]  = 8'hCF;
		frame_buf[6]  = 8'h00;
		frame_buf[7]  = 8'h80;
		frame_buf[8]  = 8'hFF;
		frame_buf[9]  = 8'h7F;
		frame_buf[10] = 8'hFF;
		frame_buf[11] = 8'hFF;
		frame_buf[12] = 8'h00;
		frame_buf[13] = 8'hFF;
		frame_buf[14] = 8'h01;
		frame_buf[15] = 8'h80;
		// Bytes past the store are counted toward the frame length only.
		frame_buf[16] = 8'hAA;
		frame_buf[17] = 8'h55;
		send_frame();
		send_item(CMD_IDLE, 8'hFF);
		wait_for_results();
	endtask

	// One random frame under each of a single low bit, all ones and a random
	// mask. The frame under the single-bit mask hits through the previous key
	// code left by the directed frame.
	task automatic test_key_mask_settings();
		logic [15:0] masks [3];
		masks[0] = 16'h0001;
		masks[1] = 16'hFFFF;
		masks[2] = 16'($urandom_range(1, 16'hFFFE));
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		foreach (masks[m]) begin
			write_key_mask(masks[m]);
			if ($urandom_range(0, 3) == 0) begin
				send_item(CMD_IDLE, 8'($urandom_range(0, 255)));
			end
			fill_random_frame();
			send_frame();
			wait_for_results();
		end
	endtask

	// Frames of the wrong length must vanish without touching the totals or
	// the previous key code: one byte short, one byte long, and a burst that
	// overflows the receive buffer. A valid frame afterwards shows the count
	// restarted cleanly. Runs with the mask back at zero and with no idling on
	// either side, as one long unbroken stretch.
	task automatic test_broken_sequences();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		write_key_mask(16'h0000);
		send_burst(FRAME_LEN - 1);
		send_burst(FRAME_LEN + 1);
		send_burst(BUF_LEN + 2);
		fill_random_frame();
		send_frame();
		send_burst($urandom_range(0, 6));
		fill_random_frame();
		send_frame();
		wait_for_results();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// frames, so the frame queue fills and the decoder stalls its input. After
	// the hold-off the sender pauses until every field has drained.
	task automatic test_backpressure();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		write_key_mask(16'h8000);
		hold_len = HOLD_CYCLES;
		hold_req++;
		for (int f = 0; f < 3; f++) begin
			fill_random_frame();
			send_frame();
		end
		wait_for_results();
	endtask

	// -------------------------------------------------------------------------
	// Test sequence
	// -------------------------------------------------------------------------
	initial begin : test_sequence
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_BYTE;
		in_ch.rx_byte = 8'h00;
		key_mask_we = 1'b0;
		key_mask_wdata = 16'h0000;
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		hold_len = 0;
		hold_req = 0;
		rx_count = 0;
		prev_keys = '0;
		mask_model = '0;
		foreach (mouse_sum[i]) mouse_sum[i] = '0;
		foreach (rx_store[i]) rx_store[i] = '0;
		items_sent = 0;
		frames_decoded = 0;
		idles_discarded = 0;
		results_checked = 0;
		mismatch_count = 0;
		cycle_count = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_frame();
		test_key_mask_settings();
		test_broken_sequences();
		test_backpressure();
		wait_for_results();

		$display("Covered %0d input transactions: %0d frames decoded, %0d idle events discarded.",
			items_sent, frames_decoded, idles_discarded);
		$display("Checked %0d result transactions over six key_mask values and a %0d-cycle hold-off.",
			results_checked, HOLD_CYCLES);
		if (mismatch_count == 0 && expected_fields.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
